// ----- hw/rtl/bq_pkg.sv -----
package bq_pkg;

   // Coefficient format is fixed by the register map: 24-bit signed
   localparam int COEF_BITS      = 24;
   localparam int STATE_BITS     = 32;
   localparam int NUM_COEFS      = 5;
   localparam int CSR_INDEX_BITS = 3;

   // Register indexes of the coefficient bank
   localparam logic [CSR_INDEX_BITS-1:0] IDX_B0 = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] IDX_B1 = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] IDX_B2 = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] IDX_A1 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] IDX_A2 = 3'd4;

   // Operand pair fed to the shared multiplier
   typedef enum logic [2:0] {
      MUL_B0_X = 3'd0,
      MUL_B1_X = 3'd1,
      MUL_A1_Y = 3'd2,
      MUL_B2_X = 3'd3,
      MUL_A2_Y = 3'd4
   } mul_sel_type;

   // Controller to datapath commands
   typedef struct packed {
      logic        load_x;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        acc_load;
      logic        y_load;
      logic        d1_load;
      logic        d2_load;
      logic        out_load;
   } dp_cmd_type;

   // Coefficient register write
   typedef struct packed {
      logic                      we;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [COEF_BITS-1:0]      data;
   } csr_write_type;

endpackage

// ----- hw/rtl/biquad_tdf2_filter.sv -----
// Biquad section, transposed direct form II, one shared multiplier.
// rsp_valid is registered and rises after an accepted word has walked P0, Y, P3, D1, P4 and D2.
// A new word is accepted only in idle, once the last one is done (five products through one multiplier).
// A stalled result holds the filter in its last step until the word is taken.
// Reset (sync, active high) clears coefficients, both delays and rsp_valid.
module biquad_tdf2_filter #(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   // sample input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [SAMPLE_BITS-1:0]            req_sample_in,
   // filtered output
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [SAMPLE_BITS-1:0]            rsp_sample_out,
   // coefficient writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bq_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bq_pkg::COEF_BITS-1:0]      csr_data
);

   // Per word the controller walks:
   //   P0: prod = b0*x
   //   Y : y = sat(rnd(prod) + d1), prod = b1*x
   //   P3: acc = b1*x, prod = a1*y
   //   D1: d1 = sat32(rnd(acc - prod) + d2), prod = b2*x
   //   P4: acc = b2*x, prod = a2*y
   //   D2: d2 = sat32(rnd(acc - prod)), result word loaded
   // d1 is read in Y before it is rewritten in D1, and old d2 is read in D1
   // before D2 overwrites it, so no shadow copies of the state are needed.

   bq_pkg::dp_cmd_type    cmd;
   bq_pkg::csr_write_type csr_wr;

   // the user must change coefficients only while idle; the block does not enforce it, and writes are always taken
   assign csr_ready    = 1'b1;
   assign csr_wr.we    = csr_valid && csr_ready;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   bq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   bq_datapath #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .csr_wr         (csr_wr),
      .req_sample_in  (req_sample_in),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule

// ----- hw/rtl/bq_datapath.sv -----
module bq_datapath #(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bq_pkg::dp_cmd_type         cmd,
   input  bq_pkg::csr_write_type      csr_wr,
   input  logic [SAMPLE_BITS-1:0]     req_sample_in,
   output logic [SAMPLE_BITS-1:0]     rsp_sample_out
);

   localparam int PROD_W = bq_pkg::COEF_BITS + SAMPLE_BITS;
   localparam int ACC_W  = PROD_W + 2;
   localparam int SUM_W  = ACC_W + 1;
   localparam int SB     = SAMPLE_BITS;
   localparam int ST     = bq_pkg::STATE_BITS;
   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

   logic signed [bq_pkg::COEF_BITS-1:0] b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic signed [SB-1:0]     x_ff, y_ff, out_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in, acc_ff;
   logic signed [ST-1:0]     d1_ff, d2_ff;

   logic signed [bq_pkg::COEF_BITS-1:0] coef_sel;
   logic signed [SB-1:0]     op_sel;
   logic signed [ACC_W-1:0]  prod_ext, diff, rnd_y_pre, rnd_d_pre, rnd_y, rnd_d;
   logic signed [SUM_W-1:0]  sum_y, sum_d1, sum_d2;
   logic signed [SB-1:0]     y_in;
   logic signed [ST-1:0]     d1_in, d2_in;

   function automatic logic [SB-1:0] sat_sample(input logic [SUM_W-1:0] v);
      logic [SUM_W-SB:0] upper;
      upper = v[SUM_W-1:SB-1];
      if ((&upper) || !(|upper))
         return v[SB-1:0];
      return v[SUM_W-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
   endfunction

   function automatic logic [ST-1:0] sat_state(input logic [SUM_W-1:0] v);
      logic [SUM_W-ST:0] upper;
      upper = v[SUM_W-1:ST-1];
      if ((&upper) || !(|upper))
         return v[ST-1:0];
      return v[SUM_W-1] ? {1'b1, {(ST-1){1'b0}}} : {1'b0, {(ST-1){1'b1}}};
   endfunction

   // shared multiplier operand select
   always_comb begin
      coef_sel = b0_ff;
      op_sel   = x_ff;
      case (cmd.mul_sel)
         bq_pkg::MUL_B0_X: begin coef_sel = b0_ff; op_sel = x_ff; end
         bq_pkg::MUL_B1_X: begin coef_sel = b1_ff; op_sel = x_ff; end
         bq_pkg::MUL_A1_Y: begin coef_sel = a1_ff; op_sel = y_ff; end
         bq_pkg::MUL_B2_X: begin coef_sel = b2_ff; op_sel = x_ff; end
         bq_pkg::MUL_A2_Y: begin coef_sel = a2_ff; op_sel = y_ff; end
         default:          begin coef_sel = b0_ff; op_sel = x_ff; end
      endcase
   end

   assign prod_in = coef_sel * op_sel;

   // rounding: add half an LSB, then arithmetic shift
   always_comb begin
      prod_ext  = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      diff      = {{(ACC_W-PROD_W){acc_ff[PROD_W-1]}}, acc_ff} - prod_ext;
      rnd_y_pre = prod_ext + RND_HALF;
      rnd_d_pre = diff + RND_HALF;
      rnd_y     = rnd_y_pre >>> COEF_FRAC_BITS;
      rnd_d     = rnd_d_pre >>> COEF_FRAC_BITS;
      sum_y     = {rnd_y[ACC_W-1], rnd_y} + {{(SUM_W-ST){d1_ff[ST-1]}}, d1_ff};
      sum_d1    = {rnd_d[ACC_W-1], rnd_d} + {{(SUM_W-ST){d2_ff[ST-1]}}, d2_ff};
      sum_d2    = {rnd_d[ACC_W-1], rnd_d};
      y_in      = sat_sample(sum_y);
      d1_in     = sat_state(sum_d1);
      d2_in     = sat_state(sum_d2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff <= '0;
         b1_ff <= '0;
         b2_ff <= '0;
         a1_ff <= '0;
         a2_ff <= '0;
      end else if (csr_wr.we) begin
         unique case (csr_wr.index)
            bq_pkg::IDX_B0: b0_ff <= csr_wr.data;
            bq_pkg::IDX_B1: b1_ff <= csr_wr.data;
            bq_pkg::IDX_B2: b2_ff <= csr_wr.data;
            bq_pkg::IDX_A1: a1_ff <= csr_wr.data;
            bq_pkg::IDX_A2: a2_ff <= csr_wr.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= '0;
         d2_ff <= '0;
      end else begin
         if (cmd.d1_load) d1_ff <= d1_in;
         if (cmd.d2_load) d2_ff <= d2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_x)   x_ff    <= req_sample_in;
      if (cmd.mul_en)   prod_ff <= prod_in;
      if (cmd.acc_load) acc_ff  <= prod_ff;
      if (cmd.y_load)   y_ff    <= y_in;
      if (cmd.out_load) out_ff  <= y_ff;
   end

   assign rsp_sample_out = out_ff;

endmodule

// ----- hw/rtl/bq_ctrl.sv -----
module bq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output bq_pkg::dp_cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_P0   = 7'b0000010,
      ST_Y    = 7'b0000100,
      ST_P3   = 7'b0001000,
      ST_D1   = 7'b0010000,
      ST_P4   = 7'b0100000,
      ST_D2   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept, out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.mul_sel  = bq_pkg::MUL_B0_X;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load_x = accept;
            if (accept) state_in = ST_P0;
         end
         ST_P0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = bq_pkg::MUL_B0_X;
            state_in    = ST_Y;
         end
         ST_Y: begin
            cmd.y_load  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = bq_pkg::MUL_B1_X;
            state_in    = ST_P3;
         end
         ST_P3: begin
            cmd.acc_load = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = bq_pkg::MUL_A1_Y;
            state_in     = ST_D1;
         end
         ST_D1: begin
            cmd.d1_load = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = bq_pkg::MUL_B2_X;
            state_in    = ST_P4;
         end
         ST_P4: begin
            cmd.acc_load = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = bq_pkg::MUL_A2_Y;
            state_in     = ST_D2;
         end
         ST_D2: begin
            if (out_free) begin
               cmd.d2_load  = 1'b1;
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_sched_len: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##6 (state_ff == ST_D2))
      else $error("item did not reach the final step on schedule");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("output word overwritten before it was taken");

   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_D2))
      else $error("result valid raised outside the final step");

   a_d2_with_out: assert property (@(posedge clock) disable iff (reset)
      cmd.d2_load |-> (cmd.out_load && state_ff == ST_D2))
      else $error("second delay updated without retiring the word");

endmodule
